@@ rtl/core/itr_pkg.sv @@
// ----------------------------------------------------------------------------
// itr_pkg
// Shared types, constants and lookup functions of the Roman numeral encoder.
// ----------------------------------------------------------------------------
package itr_pkg;

    localparam int unsigned ValueWidth = 12;
    localparam int unsigned SymWidth   = 8;
    localparam int unsigned FifoDepth  = 2;
    localparam int unsigned MinValue   = 1;
    localparam int unsigned MaxValue   = 3999;

    // Decimal digits of one number, ones in digit[0], thousands in digit[3]
    typedef struct packed {
        logic             err;
        logic [3:0][3:0]  digit;
    } t_digits;

    // Role of a letter inside one decimal place
    localparam logic [1:0] ROLE_ONE  = 2'd0;
    localparam logic [1:0] ROLE_FIVE = 2'd1;
    localparam logic [1:0] ROLE_TEN  = 2'd2;

    localparam logic [7:0] LETTER_I = 8'h49;
    localparam logic [7:0] LETTER_V = 8'h56;
    localparam logic [7:0] LETTER_X = 8'h58;
    localparam logic [7:0] LETTER_L = 8'h4C;
    localparam logic [7:0] LETTER_C = 8'h43;
    localparam logic [7:0] LETTER_D = 8'h44;
    localparam logic [7:0] LETTER_M = 8'h4D;
    localparam logic [7:0] LETTER_NONE = 8'h00;

    // k times the weight of the place handled at step (0: thousands .. 2: tens)
    function automatic logic [13:0] place_mult(input logic [1:0] step, input logic [3:0] k);
        logic [13:0] w;
        case (step)
            2'd0:    w = 14'd1000;
            2'd1:    w = 14'd100;
            default: w = 14'd10;
        endcase
        return 14'(w * {10'd0, k});
    endfunction

    // Number of letters that one decimal digit takes
    function automatic logic [2:0] digit_len(input logic [3:0] d);
        logic [2:0] n;
        case (d)
            4'd1, 4'd5:       n = 3'd1;
            4'd2, 4'd4, 4'd6,
            4'd9:             n = 3'd2;
            4'd3, 4'd7:       n = 3'd3;
            4'd8:             n = 3'd4;
            default:          n = 3'd0;
        endcase
        return n;
    endfunction

    // Role of letter k of digit d
    function automatic logic [1:0] digit_role(input logic [3:0] d, input logic [1:0] k);
        logic [1:0] r;
        case (d)
            4'd4:                   r = (k == 2'd0) ? ROLE_ONE : ROLE_FIVE;
            4'd9:                   r = (k == 2'd0) ? ROLE_ONE : ROLE_TEN;
            4'd5, 4'd6, 4'd7, 4'd8: r = (k == 2'd0) ? ROLE_FIVE : ROLE_ONE;
            default:                r = ROLE_ONE;
        endcase
        return r;
    endfunction

    // Letter for a role at a decimal place (0: ones .. 3: thousands)
    function automatic logic [7:0] roman_letter(input logic [1:0] pos, input logic [1:0] role);
        logic [7:0] s;
        case (pos)
            2'd3: s = LETTER_M;
            2'd2: begin
                case (role)
                    ROLE_FIVE: s = LETTER_D;
                    ROLE_TEN:  s = LETTER_M;
                    default:   s = LETTER_C;
                endcase
            end
            2'd1: begin
                case (role)
                    ROLE_FIVE: s = LETTER_L;
                    ROLE_TEN:  s = LETTER_C;
                    default:   s = LETTER_X;
                endcase
            end
            default: begin
                case (role)
                    ROLE_FIVE: s = LETTER_V;
                    ROLE_TEN:  s = LETTER_X;
                    default:   s = LETTER_I;
                endcase
            end
        endcase
        return s;
    endfunction

endpackage

@@ rtl/core/itr_front.sv @@
// ----------------------------------------------------------------------------
// itr_front
// Accepts a number, checks its range and splits it into decimal digits,
// one place per cycle.
// ----------------------------------------------------------------------------
module itr_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [itr_pkg::ValueWidth-1:0]       i_value,
    output logic                                 o_push,
    output itr_pkg::t_digits                     o_item,
    input  logic                                 i_full
);

    typedef enum logic [2:0] {
        F_IDLE  = 3'b001,
        F_DIGIT = 3'b010,
        F_PUSH  = 3'b100
    } t_fstate;

    t_fstate                          r_state, n_state;
    logic [itr_pkg::ValueWidth-1:0]   r_rest, n_rest;
    logic [1:0]                       r_step, n_step;
    itr_pkg::t_digits                 r_item, n_item;

    logic [3:0]                       digit;
    logic [itr_pkg::ValueWidth-1:0]   sub;

    // Largest multiple of the place weight not above the rest
    always_comb begin
        digit = 4'd0;
        sub   = '0;
        for (int k = 1; k <= 9; k++) begin
            if ({2'b00, r_rest} >= itr_pkg::place_mult(r_step, 4'(k))) begin
                digit = 4'(k);
                sub   = itr_pkg::ValueWidth'(itr_pkg::place_mult(r_step, 4'(k)));
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_rest  = r_rest;
        n_step  = r_step;
        n_item  = r_item;
        case (r_state)
            F_IDLE: begin
                if (i_valid) begin
                    n_rest     = i_value;
                    n_step     = 2'd0;
                    n_item.err = (i_value < itr_pkg::ValueWidth'(itr_pkg::MinValue)) ||
                                 (i_value > itr_pkg::ValueWidth'(itr_pkg::MaxValue));
                    n_state    = F_DIGIT;
                end
            end
            F_DIGIT: begin
                n_item.digit[2'(2'd3 - r_step)] = digit;
                n_rest = r_rest - sub;
                n_step = r_step + 2'd1;
                if (r_step == 2'd2) begin
                    n_item.digit[0] = n_rest[3:0];
                    n_state         = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!i_full) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_rest <= n_rest;
        r_step <= n_step;
        r_item <= n_item;
    end

    assign o_ready = (r_state == F_IDLE);
    assign o_push  = (r_state == F_PUSH) && !i_full;
    assign o_item  = r_item;

endmodule

@@ rtl/core/itr_fifo.sv @@
// ----------------------------------------------------------------------------
// itr_fifo
// Small register queue between the digit splitter and the letter sequencer.
// ----------------------------------------------------------------------------
module itr_fifo #(
    parameter int unsigned DEPTH = itr_pkg::FifoDepth,
    parameter int unsigned WIDTH = $bits(itr_pkg::t_digits)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [WIDTH-1:0]  i_data,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_pop,
    output logic [WIDTH-1:0]  o_data
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wptr, r_rptr;
    logic [CW-1:0]    r_count;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : AW'(p + AW'(1));
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= ptr_inc(r_wptr);
            end
            if (i_pop) begin
                r_rptr <= ptr_inc(r_rptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];

endmodule

@@ rtl/core/itr_back.sv @@
// ----------------------------------------------------------------------------
// itr_back
// Walks the decimal digits of one number and emits its Roman letters, one per
// cycle while the output is not stalled, through an output register.
// ----------------------------------------------------------------------------
module itr_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  itr_pkg::t_digits                  i_item,
    output logic                              o_pop,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [itr_pkg::SymWidth-1:0]      o_symbol,
    output logic                              o_last,
    output logic                              o_error
);

    typedef enum logic [1:0] {
        B_IDLE = 2'b01,
        B_RUN  = 2'b10
    } t_bstate;

    t_bstate                         r_state;
    itr_pkg::t_digits                r_item;
    logic [1:0]                      r_pos;
    logic [1:0]                      r_k;
    logic                            r_out_valid;
    logic [itr_pkg::SymWidth-1:0]    r_symbol;
    logic                            r_last;
    logic                            r_error;

    logic [1:0]                      start_pos;
    logic [1:0]                      next_pos;
    logic                            more_below;
    logic [3:0]                      cur_digit;
    logic                            digit_done;
    logic                            fire;
    logic [itr_pkg::SymWidth-1:0]    cur_symbol;

    // Highest nonzero place of the incoming number
    always_comb begin
        start_pos = 2'd0;
        for (int q = 0; q < 4; q++) begin
            if (i_item.digit[q] != 4'd0) begin
                start_pos = 2'(q);
            end
        end
    end

    // Next nonzero place below the current one
    always_comb begin
        next_pos   = 2'd0;
        more_below = 1'b0;
        for (int q = 0; q < 4; q++) begin
            if ((2'(q) < r_pos) && (r_item.digit[q] != 4'd0)) begin
                next_pos   = 2'(q);
                more_below = 1'b1;
            end
        end
    end

    assign cur_digit  = r_item.digit[r_pos];
    assign digit_done = ({1'b0, r_k} + 3'd1) == itr_pkg::digit_len(cur_digit);
    assign cur_symbol = itr_pkg::roman_letter(r_pos, itr_pkg::digit_role(cur_digit, r_k));
    assign fire       = (r_state == B_RUN) && (!r_out_valid || i_ready);
    assign o_pop      = (r_state == B_IDLE) && i_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                B_IDLE: begin
                    if (i_valid) begin
                        r_state <= B_RUN;
                    end
                end
                B_RUN: begin
                    if (fire && (r_item.err || (digit_done && !more_below))) begin
                        r_state <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end

        if (o_pop) begin
            r_item <= i_item;
            r_pos  <= start_pos;
            r_k    <= 2'd0;
        end else if (fire) begin
            if (digit_done) begin
                r_pos <= next_pos;
                r_k   <= 2'd0;
            end else begin
                r_k   <= r_k + 2'd1;
            end
        end

        if (fire) begin
            if (r_item.err) begin
                r_symbol <= itr_pkg::LETTER_NONE;
                r_last   <= 1'b1;
                r_error  <= 1'b1;
            end else begin
                r_symbol <= cur_symbol;
                r_last   <= digit_done && !more_below;
                r_error  <= 1'b0;
            end
        end
    end

    assign o_valid  = r_out_valid;
    assign o_symbol = r_symbol;
    assign o_last   = r_last;
    assign o_error  = r_error;

endmodule

@@ rtl/core/integer_to_roman_encoder.sv @@
// Path: the first letter passes the 3 digit steps in the splitter, the queue
// push, the pop into the letter sequencer and its output register.
// Throughput: the letter sequencer emits one letter per cycle while the output
// is not stalled, idling between numbers; an out of range number gives one
// error item. The splitter takes a new number once the last one is queued.
// Reset: synchronous, active low; clears the FSMs, output valid and the queue.
// ----------------------------------------------------------------------------
// integer_to_roman_encoder
// Converts a number from 1 to 3999 into a stream of Roman numeral letters.
// ----------------------------------------------------------------------------
module integer_to_roman_encoder #(
    parameter int unsigned FIFO_DEPTH = itr_pkg::FifoDepth
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [11:0] value, [15:12] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] symbol
    output logic        m_axis_tlast,
    output logic        m_axis_tuser    // [0] error
);

    logic              push;
    logic              full;
    logic              q_valid;
    logic              pop;
    itr_pkg::t_digits  front_item;
    itr_pkg::t_digits  q_item;

    itr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_value (s_axis_tdata[itr_pkg::ValueWidth-1:0]),
        .o_push  (push),
        .o_item  (front_item),
        .i_full  (full)
    );

    itr_fifo #(
        .DEPTH (FIFO_DEPTH),
        .WIDTH ($bits(itr_pkg::t_digits))
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_item),
        .o_full  (full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_data  (q_item)
    );

    itr_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_item   (q_item),
        .o_pop    (pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_symbol (m_axis_tdata),
        .o_last   (m_axis_tlast),
        .o_error  (m_axis_tuser)
    );

endmodule
